@@ hdl/ric_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ric_pkg: shared types and constants of the record integrity checker
// Record layout, register map, fail codes and the CRC-32 byte update.
// ----------------------------------------------------------------------------
package ric_pkg;

	localparam int ID_BYTES  = 32;
	localparam int ID_WORDS  = ID_BYTES / 8;
	localparam int REC_LEN   = 44;
	localparam int CRC_END   = 8 + ID_BYTES;
	localparam int COUNT_W   = 6;
	localparam int PADDR_W   = 6;
	localparam int PDATA_W   = 64;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
	localparam logic [31:0] CRC_ONES       = 32'hFFFF_FFFF;
	localparam logic [31:0] MAGIC_RESET    = 32'h4E55_564C;
	localparam logic [15:0] VERSION_RESET  = 16'd1;
	localparam logic [7:0]  STATE_ACTIVE   = 8'd1;
	localparam logic [7:0]  STATE_STANDBY  = 8'd2;

	// Register index, taken from paddr[5:3].
	typedef enum logic [2:0] {
		REG_MAGIC   = 3'd0,
		REG_VERSION = 3'd1,
		REG_ID0     = 3'd2,
		REG_ID1     = 3'd3,
		REG_ID2     = 3'd4,
		REG_ID3     = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		FAIL_NONE     = 3'd0,
		FAIL_LENGTH   = 3'd1,
		FAIL_MAGIC    = 3'd2,
		FAIL_VERSION  = 3'd3,
		FAIL_RESERVED = 3'd4,
		FAIL_STATE    = 3'd5,
		FAIL_IDENTITY = 3'd6,
		FAIL_CRC      = 3'd7
	} fail_code_t;

	typedef struct packed {
		logic [31:0]                 magic;
		logic [15:0]                 version;
		logic [ID_WORDS-1:0][63:0]   id_word;
	} cfg_t;

	typedef struct packed {
		logic        ok;
		fail_code_t  code;
		logic [7:0]  state;
	} verdict_t;

	// Reflected CRC-32 update over one byte, bit at a time.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

@@ hdl/record_integrity_checker_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_integrity_checker_top: state record integrity checker
// Checks a 44-byte record streamed one byte per item and reports a verdict.
// ----------------------------------------------------------------------------
// Usage: a record enters on the input channel (in_valid / in_ready) as one
// item per byte, data_byte in storage order, with last_byte set on the final
// byte. Only the final byte produces a result on the output channel
// (out_valid / out_ready): record_ok, fail_code and the captured state_value.
// Bytes 0 to 39 are covered by a reflected CRC-32 that is compared with the
// stored CRC in bytes 40 to 43; length, magic, version, reserved byte, state
// and identity are checked too, and the first failure is reported.
// Throughput is one byte per cycle while no final byte waits for the output
// register; each item passes the input register, where the CRC byte update
// and the field capture are done. The final byte's verdict is then loaded
// into the output register, which drives out_valid.
// When the receiver stalls, the result waits in the output register while
// further non-final bytes are still taken; a second final byte waits in the
// input register until the output register frees up.
// Reset clears the record state and the pipeline and loads the register
// defaults. Registers sit on an APB port at byte address 8*index, 64 bits.
// ----------------------------------------------------------------------------
module record_integrity_checker_top (
	input  logic                        clk,
	input  logic                        arst_n,
	// APB configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ric_pkg::PADDR_W-1:0] paddr,
	input  logic [ric_pkg::PDATA_W-1:0] pwdata,
	output logic [ric_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	// Byte input channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  data_byte,
	input  logic                        last_byte,
	// Verdict output channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        record_ok,
	output logic [2:0]                  fail_code,
	output logic [7:0]                  state_value
);
	import ric_pkg::*;

	cfg_t      cfg_q;
	reg_idx_t  reg_idx;
	logic      wr_en;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance_s1;

	verdict_t  verdict;
	verdict_t  res_s2;
	logic      valid_s2;

	// ------------------------------------------------------------------
	// Configuration registers. The register index comes from the address
	// bits above the 8-byte lane; unused indexes read as zero and ignore
	// writes.
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:3]);
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic   <= MAGIC_RESET;
			cfg_q.version <= VERSION_RESET;
			cfg_q.id_word <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MAGIC:   cfg_q.magic      <= pwdata[31:0];
				REG_VERSION: cfg_q.version    <= pwdata[15:0];
				REG_ID0:     cfg_q.id_word[0] <= pwdata;
				REG_ID1:     cfg_q.id_word[1] <= pwdata;
				REG_ID2:     cfg_q.id_word[2] <= pwdata;
				REG_ID3:     cfg_q.id_word[3] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MAGIC:   prdata = {32'd0, cfg_q.magic};
			REG_VERSION: prdata = {48'd0, cfg_q.version};
			REG_ID0:     prdata = cfg_q.id_word[0];
			REG_ID1:     prdata = cfg_q.id_word[1];
			REG_ID2:     prdata = cfg_q.id_word[2];
			REG_ID3:     prdata = cfg_q.id_word[3];
			default:     prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Input register. A non-final byte always moves on; a final byte
	// moves on only when the output register is free or being emptied.
	// ------------------------------------------------------------------
	assign advance_s1 = valid_s1 && (!last_s1 || !valid_s2 || out_ready);
	assign in_ready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// Record state, CRC and verdict.
	ric_record u_record (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_en   (advance_s1),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.cfg       (cfg_q),
		.verdict   (verdict)
	);

	// ------------------------------------------------------------------
	// Output register holding the verdict until the receiver takes it.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1 && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && last_s1) begin
			res_s2 <= verdict;
		end
	end

	assign out_valid   = valid_s2;
	assign record_ok   = res_s2.ok;
	assign fail_code   = res_s2.code;
	assign state_value = res_s2.state;

endmodule

@@ hdl/ric_record.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ric_record: record state and verdict logic
// Tracks position, CRC and captured fields of the current record and forms
// the verdict for the final byte.
// ----------------------------------------------------------------------------
module ric_record (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_en,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	input  ric_pkg::cfg_t       cfg,
	output ric_pkg::verdict_t   verdict
);
	import ric_pkg::*;

	logic [COUNT_W-1:0] count_q;
	logic [31:0]        crc_q;
	logic [31:0]        magic_q;
	logic [15:0]        version_q;
	logic [7:0]         state_q;
	logic [7:0]         reserved_q;
	logic [31:0]        crc_stored_q;
	logic               id_mismatch_q;

	logic [31:0]        crc_d;
	logic [31:0]        magic_d;
	logic [15:0]        version_d;
	logic [7:0]         state_d;
	logic [7:0]         reserved_d;
	logic [31:0]        crc_stored_d;
	logic               id_mismatch_d;
	logic [COUNT_W-1:0] count_d;
	logic [COUNT_W-1:0] id_pos;
	logic [7:0]         id_bytes [ID_BYTES];
	logic [7:0]         want;

	// Identity byte i sits in word i/8, byte 0 of a word in its top bits.
	always_comb begin
		for (int i = 0; i < ID_BYTES; i++) begin
			id_bytes[i] = cfg.id_word[i[4:3]][8*(7-i[2:0]) +: 8];
		end
	end

	assign id_pos = count_q - COUNT_W'(8);
	assign want   = id_bytes[id_pos[4:0]];

	always_comb begin
		crc_d         = crc_q;
		magic_d       = magic_q;
		version_d     = version_q;
		state_d       = state_q;
		reserved_d    = reserved_q;
		crc_stored_d  = crc_stored_q;
		id_mismatch_d = id_mismatch_q;
		count_d       = (count_q != COUNT_MAX) ? count_q + 1'b1 : count_q;

		if (count_q < COUNT_W'(CRC_END)) begin
			crc_d = crc_byte(crc_q, data_byte);
		end

		priority if (count_q < COUNT_W'(4)) begin
			magic_d[8*count_q[1:0] +: 8] = data_byte;
		end else if (count_q < COUNT_W'(6)) begin
			version_d[8*count_q[0] +: 8] = data_byte;
		end else if (count_q == COUNT_W'(6)) begin
			state_d = data_byte;
		end else if (count_q == COUNT_W'(7)) begin
			reserved_d = data_byte;
		end else if (count_q < COUNT_W'(CRC_END)) begin
			if (want != data_byte) begin
				id_mismatch_d = 1'b1;
			end
		end else if (count_q < COUNT_W'(REC_LEN)) begin
			crc_stored_d[8*id_pos[1:0] +: 8] = data_byte;
		end else begin
			// Bytes past the stored CRC are not captured.
		end
	end

	// The check order decides which failure is reported.
	always_comb begin
		priority if (count_q != COUNT_W'(REC_LEN - 1)) begin
			verdict.code = FAIL_LENGTH;
		end else if (magic_d != cfg.magic) begin
			verdict.code = FAIL_MAGIC;
		end else if (version_d != cfg.version) begin
			verdict.code = FAIL_VERSION;
		end else if (reserved_d != 8'd0) begin
			verdict.code = FAIL_RESERVED;
		end else if (state_d != STATE_ACTIVE && state_d != STATE_STANDBY) begin
			verdict.code = FAIL_STATE;
		end else if (id_mismatch_d) begin
			verdict.code = FAIL_IDENTITY;
		end else if ((crc_d ^ CRC_ONES) != crc_stored_d) begin
			verdict.code = FAIL_CRC;
		end else begin
			verdict.code = FAIL_NONE;
		end
		verdict.ok    = (verdict.code == FAIL_NONE);
		verdict.state = state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			crc_q         <= CRC_ONES;
			magic_q       <= '0;
			version_q     <= '0;
			state_q       <= '0;
			reserved_q    <= '0;
			crc_stored_q  <= '0;
			id_mismatch_q <= 1'b0;
		end else if (byte_en) begin
			if (last_byte) begin
				count_q       <= '0;
				crc_q         <= CRC_ONES;
				magic_q       <= '0;
				version_q     <= '0;
				state_q       <= '0;
				reserved_q    <= '0;
				crc_stored_q  <= '0;
				id_mismatch_q <= 1'b0;
			end else begin
				count_q       <= count_d;
				crc_q         <= crc_d;
				magic_q       <= magic_d;
				version_q     <= version_d;
				state_q       <= state_d;
				reserved_q    <= reserved_d;
				crc_stored_q  <= crc_stored_d;
				id_mismatch_q <= id_mismatch_d;
			end
		end
	end

endmodule

@@ sim/tb_record_integrity_checker_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_record_integrity_checker_top: self-checking bench of the record checker
// Streams 44-byte state records, good and damaged, plus noise, under several
// register settings, and checks every verdict against a behavioral predictor.
// ----------------------------------------------------------------------------
module tb_record_integrity_checker_top;
	import ric_pkg::*;

	// Number of random byte items to stream after the directed records.
	localparam int RANDOM_ITEMS = 250;
	// Indexes past the register list; writes there must change nothing.
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;
	// Damage that can be applied to a record before it is sent.
	localparam logic [5:0] BAD_NONE     = 6'b000000;
	localparam logic [5:0] BAD_MAGIC    = 6'b000001;
	localparam logic [5:0] BAD_VERSION  = 6'b000010;
	localparam logic [5:0] BAD_RESERVED = 6'b000100;
	localparam logic [5:0] BAD_STATE    = 6'b001000;
	localparam logic [5:0] BAD_IDENTITY = 6'b010000;
	localparam logic [5:0] BAD_CRC      = 6'b100000;
	localparam int MAX_PRINTS = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = 8'd0;
	logic last_byte = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic record_ok;
	logic [2:0] fail_code;
	logic [7:0] state_value;

	record_integrity_checker_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.record_ok   (record_ok),
		.fail_code   (fail_code),
		.state_value (state_value)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Register copies as the block should hold them.
	logic [31:0] cfg_magic;
	logic [15:0] cfg_version;
	logic [63:0] cfg_id [ID_WORDS];

	// Record state of the predictor.
	logic [COUNT_W-1:0] rec_count;
	logic [31:0] run_crc;
	logic [31:0] seen_magic;
	logic [15:0] seen_version;
	logic [7:0]  seen_state;
	logic [7:0]  seen_reserved;
	logic [31:0] seen_crc;
	logic        id_bad;

	// Verdicts predicted but not yet delivered, oldest first.
	verdict_t verdicts_due [$];

	int err_count = 0;
	int items_taken = 0;
	// Percentage chance that the receiver starts a stall on a cycle, or the sender an idle burst before an item.
	int idle_pct = 0;
	int stall_left = 0;

	task automatic flag_error(input string msg);
		err_count++;
		if (err_count <= MAX_PRINTS) begin
			$display("ERROR at %0t ns: %s", $time, msg);
		end
	endtask

	// Reflected CRC-32 update, feeding the byte in one bit per step.
	function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = {1'b0, c[31:1]} ^ (fb ? CRC_POLY : 32'd0);
		end
		return c;
	endfunction

	task automatic clear_record();
		rec_count = '0;
		run_crc = CRC_ONES;
		seen_magic = '0;
		seen_version = '0;
		seen_state = '0;
		seen_reserved = '0;
		seen_crc = '0;
		id_bad = 1'b0;
	endtask

	// Takes one accepted byte into the predicted record state. On the final
	// byte the verdict is formed, first failing check wins, and the record
	// state starts over.
	task automatic absorb_byte(input logic [7:0] b, input logic last);
		int p;
		int k;
		verdict_t v;
		p = rec_count;
		if (p < CRC_END) begin
			run_crc = crc32_step(run_crc, b);
		end
		if (p < 4) begin
			seen_magic[8*p +: 8] = b;
		end else if (p < 6) begin
			seen_version[8*(p-4) +: 8] = b;
		end else if (p == 6) begin
			seen_state = b;
		end else if (p == 7) begin
			seen_reserved = b;
		end else if (p < CRC_END) begin
			// Identity bytes are compared with the register as it is now.
			k = p - 8;
			if (cfg_id[k/8][63-8*(k%8) -: 8] != b) begin
				id_bad = 1'b1;
			end
		end else if (p < REC_LEN) begin
			seen_crc[8*(p-CRC_END) +: 8] = b;
		end
		// The position counter sticks at its top value on long records.
		if (rec_count != COUNT_MAX) begin
			rec_count = rec_count + 1'b1;
		end
		if (last) begin
			if (p != REC_LEN - 1) begin
				v.code = FAIL_LENGTH;
			end else if (seen_magic != cfg_magic) begin
				v.code = FAIL_MAGIC;
			end else if (seen_version != cfg_version) begin
				v.code = FAIL_VERSION;
			end else if (seen_reserved != 8'd0) begin
				v.code = FAIL_RESERVED;
			end else if (seen_state != STATE_ACTIVE && seen_state != STATE_STANDBY) begin
				v.code = FAIL_STATE;
			end else if (id_bad) begin
				v.code = FAIL_IDENTITY;
			end else if (~run_crc != seen_crc) begin
				v.code = FAIL_CRC;
			end else begin
				v.code = FAIL_NONE;
			end
			v.ok = (v.code == FAIL_NONE);
			v.state = seen_state;
			verdicts_due.push_back(v);
			clear_record();
		end
	endtask

	// Every byte accepted on the input channel goes through the predictor.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			absorb_byte(data_byte, last_byte);
			items_taken++;
		end
	end

	// Each delivered verdict is matched against the oldest prediction.
	always @(posedge clk) begin : check_verdicts
		verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			if (verdicts_due.size() == 0) begin
				flag_error("verdict delivered with none pending");
			end else begin
				want = verdicts_due.pop_front();
				if (record_ok !== want.ok) begin
					flag_error($sformatf("record_ok %b, wanted %b", record_ok, want.ok));
				end
				if (fail_code !== want.code) begin
					flag_error($sformatf("fail_code %0d, wanted %0d (%s)",
						fail_code, want.code, want.code.name()));
				end
				if (state_value !== want.state) begin
					flag_error($sformatf("state_value %0d, wanted %0d",
						state_value, want.state));
				end
			end
		end
	end

	// Receiver: random stalls while idling is enabled.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			stall_left = $urandom_range(0, 2);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// One sender item: an optional idle burst first, then valid is held
	// with a steady payload until the handshake completes.
	task automatic push_byte(input logic [7:0] b, input logic last);
		@(negedge clk);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Drops valid and waits until every predicted verdict has arrived, then
	// lets the pipeline empty.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [63:0] reg_mask(input logic [2:0] idx);
		case (idx)
			REG_MAGIC:   return 64'h0000_0000_FFFF_FFFF;
			REG_VERSION: return 64'h0000_0000_0000_FFFF;
			default:     return '1;
		endcase
	endfunction

	// One APB transfer, setup then access; read data is taken at the
	// completing edge.
	task automatic apb_transfer(input logic wr, input logic [2:0] idx,
			input logic [63:0] val, output logic [63:0] rd);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rd = prdata;
	endtask

	// Writes a register, mirrors it in the predictor and reads it back unless it is a spare index.
	task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
		logic [63:0] rd;
		apb_transfer(1'b1, idx, val, rd);
		case (idx)
			REG_MAGIC:   cfg_magic = val[31:0];
			REG_VERSION: cfg_version = val[15:0];
			REG_ID0:     cfg_id[0] = val;
			REG_ID1:     cfg_id[1] = val;
			REG_ID2:     cfg_id[2] = val;
			REG_ID3:     cfg_id[3] = val;
			default:     ;
		endcase
		if (idx != REG_SPARE_LO && idx != REG_SPARE_HI) begin
			apb_transfer(1'b0, idx, '0, rd);
			if ((rd & reg_mask(idx)) !== (val & reg_mask(idx))) begin
				flag_error($sformatf("register %0d reads %h, wrote %h", idx, rd, val));
			end
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Builds a record that matches the current settings, damages it as asked,
	// trims or pads it to the given length and streams it out.
	task automatic send_record(input logic [5:0] damage, input int rec_len);
		logic [7:0] rec [$];
		logic [31:0] c;
		int k;
		for (int i = 0; i < 4; i++) rec.push_back(cfg_magic[8*i +: 8]);
		rec.push_back(cfg_version[7:0]);
		rec.push_back(cfg_version[15:8]);
		rec.push_back($urandom_range(0, 1) ? STATE_STANDBY : STATE_ACTIVE);
		rec.push_back(8'd0);
		for (int w = 0; w < ID_WORDS; w++) begin
			for (int j = 0; j < 8; j++) rec.push_back(cfg_id[w][63-8*j -: 8]);
		end
		if (damage & BAD_MAGIC) begin
			k = $urandom_range(0, 3);
			rec[k] = rec[k] ^ (8'd1 << $urandom_range(0, 7));
		end
		if (damage & BAD_VERSION) begin
			k = $urandom_range(4, 5);
			rec[k] = rec[k] ^ (8'd1 << $urandom_range(0, 7));
		end
		if (damage & BAD_RESERVED) begin
			rec[7] = 8'($urandom_range(1, 255));
		end
		if (damage & BAD_STATE) begin
			// Zero, the values just past and far past the legal pair.
			case ($urandom_range(0, 3))
				0:       rec[6] = 8'd0;
				1:       rec[6] = 8'd3;
				2:       rec[6] = 8'd255;
				default: rec[6] = 8'($urandom_range(3, 255));
			endcase
		end
		if (damage & BAD_IDENTITY) begin
			k = $urandom_range(8, CRC_END - 1);
			rec[k] = rec[k] ^ (8'd1 << $urandom_range(0, 7));
		end
		// The stored CRC covers the record as sent, damage included.
		c = CRC_ONES;
		for (int i = 0; i < CRC_END; i++) c = crc32_step(c, rec[i]);
		c = ~c;
		for (int i = 0; i < 4; i++) rec.push_back(c[8*i +: 8]);
		if (damage & BAD_CRC) begin
			k = $urandom_range(CRC_END, REC_LEN - 1);
			rec[k] = rec[k] ^ (8'd1 << $urandom_range(0, 7));
		end
		while (rec.size() > rec_len) void'(rec.pop_back());
		while (rec.size() < rec_len) rec.push_back(8'($urandom_range(0, 255)));
		for (int i = 0; i < rec.size(); i++) push_byte(rec[i], i == rec.size() - 1);
	endtask

	// Random bytes of random length ending in a final mark.
	task automatic send_noise(input int len);
		for (int i = 0; i < len; i++) push_byte(8'($urandom_range(0, 255)), i == len - 1);
	endtask

	function automatic logic [63:0] pick_setting();
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return '1;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	task automatic load_random_settings();
		cfg_write(REG_MAGIC, $urandom_range(0, 3) == 0 ? {32'd0, MAGIC_RESET} : pick_setting());
		cfg_write(REG_VERSION, $urandom_range(0, 3) == 0 ? {48'd0, VERSION_RESET} :
			pick_setting());
		cfg_write(REG_ID0, pick_setting());
		cfg_write(REG_ID1, pick_setting());
		cfg_write(REG_ID2, pick_setting());
		cfg_write(REG_ID3, pick_setting());
	endtask

	// Good records under the register values loaded by reset.
	task automatic test_reset_defaults();
		idle_pct = 0;
		send_record(BAD_NONE, REC_LEN);
		send_record(BAD_NONE, REC_LEN);
		drain();
	endtask

	// One record per check, two for the state check, the length cases and two priority cases.
	task automatic test_each_check();
		idle_pct = 25;
		send_record(BAD_MAGIC, REC_LEN);
		send_record(BAD_VERSION, REC_LEN);
		send_record(BAD_RESERVED, REC_LEN);
		send_record(BAD_STATE, REC_LEN);
		send_record(BAD_STATE, REC_LEN);
		send_record(BAD_IDENTITY, REC_LEN);
		send_record(BAD_CRC, REC_LEN);
		// A lone final byte never reaches the state byte, so state reads zero.
		send_record(BAD_NONE, 1);
		send_record(BAD_NONE, REC_LEN - 1);
		send_record(BAD_NONE, REC_LEN + 1);
		// Long enough to pin the position counter at its ceiling.
		send_record(BAD_NONE, 70);
		send_record(BAD_MAGIC | BAD_CRC, REC_LEN);
		send_record(BAD_RESERVED | BAD_STATE | BAD_IDENTITY, REC_LEN);
		send_record(BAD_NONE, REC_LEN);
		drain();
	endtask

	// Every register at its extremes, plus writes past the register list.
	task automatic test_register_settings();
		idle_pct = 20;
		cfg_write(REG_MAGIC, '0);
		cfg_write(REG_VERSION, '0);
		cfg_write(REG_ID0, '0);
		cfg_write(REG_ID1, '0);
		cfg_write(REG_ID2, '0);
		cfg_write(REG_ID3, '0);
		send_record(BAD_NONE, REC_LEN);
		send_record(BAD_VERSION, REC_LEN);
		drain();
		cfg_write(REG_MAGIC, '1);
		cfg_write(REG_VERSION, '1);
		cfg_write(REG_ID0, '1);
		cfg_write(REG_ID1, '1);
		cfg_write(REG_ID2, '1);
		cfg_write(REG_ID3, '1);
		send_record(BAD_NONE, REC_LEN);
		send_record(BAD_IDENTITY, REC_LEN);
		drain();
		load_random_settings();
		cfg_write(REG_SPARE_LO, {$urandom(), $urandom()});
		cfg_write(REG_SPARE_HI, '1);
		send_record(BAD_NONE, REC_LEN);
		send_record(BAD_MAGIC, REC_LEN);
		drain();
	endtask

	// Random records, half of them well formed with random content, some damaged
	// in one or several fields, some of wrong length, some pure noise; settings change per phase.
	task automatic test_random_records();
		int start_items;
		int phase;
		int r;
		start_items = items_taken;
		phase = 0;
		while (items_taken - start_items < RANDOM_ITEMS) begin
			load_random_settings();
			idle_pct = (phase % 3 == 2) ? 0 : $urandom_range(10, 50);
			repeat (8) begin
				r = $urandom_range(99);
				if (r < 50) begin
					send_record(BAD_NONE, REC_LEN);
				end else if (r < 75) begin
					send_record(BAD_NONE | (6'd1 << $urandom_range(0, 5)), REC_LEN);
				end else if (r < 82) begin
					send_record(BAD_NONE, $urandom_range(0, 1) ? $urandom_range(1, REC_LEN - 1)
						: $urandom_range(REC_LEN + 1, 72));
				end else if (r < 90) begin
					send_record(6'($urandom_range(1, 63)), REC_LEN);
				end else begin
					send_noise($urandom_range(1, 60));
				end
			end
			drain();
			phase++;
		end
		// Closing stretch with no idling on either side.
		idle_pct = 0;
		load_random_settings();
		repeat (3) send_record($urandom_range(0, 1) ? BAD_NONE : BAD_CRC, REC_LEN);
		drain();
	endtask

	initial begin
		cfg_magic = MAGIC_RESET;
		cfg_version = VERSION_RESET;
		for (int w = 0; w < ID_WORDS; w++) cfg_id[w] = '0;
		clear_record();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_each_check();
		test_register_settings();
		test_random_records();

		if (err_count == 0) begin
			$display("tb_record_integrity_checker_top OK");
		end else begin
			$display("tb_record_integrity_checker_top NOT OK");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#400000;
		$display("tb_record_integrity_checker_top NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
hdl/ric_pkg.sv
hdl/ric_record.sv
hdl/record_integrity_checker_top.sv
sim/tb_record_integrity_checker_top.sv
